// ===== hdl/avm_pkg.sv =====
// Shared constants for the battery voltage moving average block.
// Field widths, divider ratio and helper widths used by all avm_* modules.
// No dependencies.
package avm_pkg;

    localparam int SAMPLE_W = 12;
    localparam int REF_W    = 13;
    localparam int MV_W     = 14;
    localparam int MV_MAX   = 16383;

    // Equal resistor divider: the battery sits at (high + low) / low times the pin.
    localparam int DIVIDER_HIGH_KOHM = 56;
    localparam int DIVIDER_LOW_KOHM  = 56;
    localparam int DIVIDER_GAIN      = (DIVIDER_HIGH_KOHM + DIVIDER_LOW_KOHM) /
                                       DIVIDER_LOW_KOHM;

    localparam int PROD_W     = SAMPLE_W + REF_W;
    localparam int DIVIDEND_W = PROD_W + $clog2(DIVIDER_GAIN);
    localparam int STEP_W     = $clog2(MV_W);

endpackage

// ===== hdl/avm_conv.sv =====
// Converts a raw converter word and its reference into millivolts.
// Three stage pipeline: product, reciprocal multiply, correction and saturation.
// Depends on avm_pkg.
module avm_conv
    import avm_pkg::*;
#(
    parameter int ADC_BITS = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SAMPLE_W-1:0] i_adc_sample,
    input  logic [REF_W-1:0]    i_reference_mv,
    output logic                o_done,
    output logic [MV_W-1:0]     o_mv
);

    localparam int     FULL_SCALE = (1 << ADC_BITS) - 1;
    localparam longint RECIP      = (64'd1 << DIVIDEND_W) / FULL_SCALE;
    localparam int     RECIP_W    = $clog2(RECIP + 1);
    localparam int     EST_W      = DIVIDEND_W + RECIP_W;
    localparam int     Q_W        = RECIP_W + 1;
    localparam int     FIX_W      = Q_W + ADC_BITS;
    localparam int     CMP_W      = (FIX_W > DIVIDEND_W) ? FIX_W : DIVIDEND_W;

    logic                  r_v1, r_v2, r_v3;
    logic [PROD_W-1:0]     r_prod;
    logic [DIVIDEND_W-1:0] r_x;
    logic [RECIP_W-1:0]    r_est;
    logic [MV_W-1:0]       r_mv;

    logic [DIVIDEND_W-1:0] w_x;
    logic [EST_W-1:0]      w_scaled;
    logic [CMP_W-1:0]      w_back;
    logic [CMP_W-1:0]      w_rem;
    logic [Q_W-1:0]        w_q;
    logic [MV_W-1:0]       n_mv;

    // The estimate is low by at most one; one compare against full scale fixes it.
    always_comb begin
        w_x      = DIVIDEND_W'(r_prod) * DIVIDEND_W'(DIVIDER_GAIN);
        w_scaled = EST_W'(w_x) * EST_W'(RECIP);
        w_back   = (CMP_W'(r_est) << ADC_BITS) - CMP_W'(r_est);
        w_rem    = CMP_W'(r_x) - w_back;
        w_q      = Q_W'(r_est) + Q_W'(w_rem >= CMP_W'(FULL_SCALE));
        if (CMP_W'(w_q) > CMP_W'(MV_MAX)) begin
            n_mv = MV_W'(MV_MAX);
        end else begin
            n_mv = MV_W'(w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_prod <= PROD_W'(i_adc_sample) * PROD_W'(i_reference_mv);
        r_x    <= w_x;
        r_est  <= w_scaled[EST_W-1:DIVIDEND_W];
        r_mv   <= n_mv;
    end

    assign o_done = r_v3;
    assign o_mv   = r_mv;

endmodule

// ===== hdl/avm_ring.sv =====
// Window memory holding the last voltages, one write and one read port.
// Read data is registered and holds until the next read.
// Depends on avm_pkg.
module avm_ring
    import avm_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [MV_W-1:0]          o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [MV_W-1:0]          i_wr_data
);

    logic [MV_W-1:0] r_mem [DEPTH];
    logic [MV_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/avm_div.sv =====
// Restoring divider for the window total by the entry count, one quotient bit a cycle.
// The quotient is known to fit in a millivolt word, so only that many steps run.
// Depends on avm_pkg.
module avm_div
    import avm_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [MV_W+$clog2(DEPTH)-1:0]       i_dividend,
    input  logic [$clog2(DEPTH+1)-1:0]          i_divisor,
    output logic                                o_done,
    output logic [MV_W-1:0]                     o_quotient
);

    localparam int TW    = MV_W + $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic               r_busy;
    logic               r_done;
    logic [STEP_W-1:0]  r_step;
    logic [CNT_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_divisor;
    logic [MV_W-1:0]    r_work;

    logic [CNT_W:0]     w_trial;
    logic               w_ge;
    logic [CNT_W:0]     w_diff;

    always_comb begin
        w_trial = {r_rem, r_work[MV_W-1]};
        w_ge    = w_trial >= {1'b0, r_divisor};
        w_diff  = w_ge ? (w_trial - {1'b0, r_divisor}) : w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == STEP_W'(MV_W - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_step    <= '0;
            r_rem     <= CNT_W'(i_dividend[TW-1:MV_W]);
            r_work    <= i_dividend[MV_W-1:0];
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            r_rem  <= w_diff[CNT_W-1:0];
            r_work <= {r_work[MV_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_work;

endmodule

// ===== hdl/adc_voltage_moving_average.sv =====
// Battery voltage moving average: top level with the sequencer and window state.
// Instantiates avm_conv, avm_ring and avm_div; depends on avm_pkg.
//
// Each input word carries a raw converter reading and the converter reference in
// millivolts. The block turns them into the battery voltage behind an equal resistor
// divider (raw * reference * 2 / (2^ADC_BITS - 1), truncated, saturating at 16383,
// and zero for a zero reference), stores that voltage in a window of the last DEPTH
// samples and returns it together with the truncated mean of the stored samples. While
// the window is still filling, the mean is taken over the samples seen so far, and
// window_full rises with the sample that fills it. One word is worked on at a time:
// the conversion (the window memory reads the oldest entry in its shadow), the window
// update, the division of the total by the count, one quotient bit a cycle, and the
// hand-off through the hold state into the output register. The next word is taken
// once the result is in the output register, even while it still waits downstream;
// while the previous result has not been taken, the new result waits in the hold
// state and the input stays stalled. The division is the longest of these steps.
// The window memory needs no clearing after reset, because the data read from an
// entry is used only once the window is full.
module adc_voltage_moving_average
    import avm_pkg::*;
#(
    parameter int DEPTH    = 8,
    parameter int ADC_BITS = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [SAMPLE_W-1:0] i_adc_sample,
    input  logic [REF_W-1:0]    i_reference_mv,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [MV_W-1:0]     o_sample_mv,
    output logic [MV_W-1:0]     o_average_mv,
    output logic                o_window_full
);

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int TW     = MV_W + $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_DIV,
        S_HOLD
    } t_state;

    t_state            r_state, n_state;
    logic [TW-1:0]     r_total, n_total;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [MV_W-1:0]   r_sample_mv, n_sample_mv;
    logic              r_full, n_full;
    logic              r_out_valid, n_out_valid;
    logic [MV_W-1:0]   r_out_sample, n_out_sample;
    logic [MV_W-1:0]   r_out_avg, n_out_avg;
    logic              r_out_full, n_out_full;

    logic              w_accept;
    logic              w_conv_done;
    logic [MV_W-1:0]   w_conv_mv;
    logic [MV_W-1:0]   w_old_mv;
    logic              w_update;
    logic              w_out_free;
    logic              w_div_done;
    logic [MV_W-1:0]   w_quotient;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_update   = (r_state == S_CONV) && w_conv_done;
    assign w_out_free = !r_out_valid || !i_out_stall;

    avm_conv #(
        .ADC_BITS(ADC_BITS)
    ) u_conv (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_accept),
        .i_adc_sample   (i_adc_sample),
        .i_reference_mv (i_reference_mv),
        .o_done         (w_conv_done),
        .o_mv           (w_conv_mv)
    );

    // The oldest entry sits at the write slot; it is read when the word arrives
    // and replaced when the conversion lands.
    avm_ring #(
        .DEPTH(DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_slot),
        .o_rd_data (w_old_mv),
        .i_wr_en   (w_update),
        .i_wr_addr (r_slot),
        .i_wr_data (w_conv_mv)
    );

    avm_div #(
        .DEPTH(DEPTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_update),
        .i_dividend (n_total),
        .i_divisor  (n_count),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        n_slot       = r_slot;
        n_count      = r_count;
        n_sample_mv  = r_sample_mv;
        n_full       = r_full;
        n_out_sample = r_out_sample;
        n_out_avg    = r_out_avg;
        n_out_full   = r_out_full;
        n_out_valid  = r_out_valid && i_out_stall;

        // Once the window is full the new voltage replaces the oldest one in the total.
        if (r_full) begin
            n_total = r_total - TW'(w_old_mv) + TW'(w_conv_mv);
        end else begin
            n_total = r_total + TW'(w_conv_mv);
            n_count = r_count + CNT_W'(1);
        end

        if (!w_update) begin
            n_total = r_total;
            n_count = r_count;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (w_conv_done) begin
                    n_state     = S_DIV;
                    n_sample_mv = w_conv_mv;
                    n_full      = (n_count == CNT_W'(DEPTH));
                    n_slot      = (r_slot == SLOT_W'(DEPTH - 1)) ? '0 :
                                  r_slot + SLOT_W'(1);
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_sample = r_sample_mv;
                    n_out_avg    = w_quotient;
                    n_out_full   = r_full;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_slot      <= '0;
            r_count     <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_slot      <= n_slot;
            r_count     <= n_count;
            r_full      <= n_full;
            r_out_valid <= n_out_valid;
        end
        r_sample_mv  <= n_sample_mv;
        r_out_sample <= n_out_sample;
        r_out_avg    <= n_out_avg;
        r_out_full   <= n_out_full;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_sample_mv   = r_out_sample;
    assign o_average_mv  = r_out_avg;
    assign o_window_full = r_out_full;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("window count beyond depth");

    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_total == '0))
        else $error("nonzero total with an empty window");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_count == CNT_W'(DEPTH)))
        else $error("window flagged full below depth");

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its state");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("second word taken while one is in flight");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for adc_voltage_moving_average.
// Drives converter words through the valid/stall handshake and checks every result
// against an in-bench window model; depends on avm_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
    import avm_pkg::*;

    localparam int DEPTH      = 8;
    localparam int ADC_BITS   = 12;
    localparam int FULL_SCALE = (1 << ADC_BITS) - 1;

    // Run control. The watchdog limit sits well above the long receiver hold and
    // the longest random stall run, plus the time the block spends on a word.
    localparam int RANDOM_WORDS  = 1830;
    localparam int PHASE_A_END   = 600;
    localparam int PHASE_B_END   = 1200;
    localparam int HOLD_AT       = 1400;
    localparam int HOLD_LEN      = 300;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int DRAIN_CYCLES  = 40;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [REF_W-1:0]    ref_mv;
    } t_adc_word;

    typedef struct packed {
        logic [MV_W-1:0] sample_mv;
        logic [MV_W-1:0] average_mv;
        logic            window_full;
    } t_reading;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [SAMPLE_W-1:0] i_adc_sample;
    logic [REF_W-1:0]    i_reference_mv;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [MV_W-1:0]     o_sample_mv;
    logic [MV_W-1:0]     o_average_mv;
    logic                o_window_full;

    adc_voltage_moving_average #(
        .DEPTH    (DEPTH),
        .ADC_BITS (ADC_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_adc_sample   (i_adc_sample),
        .i_reference_mv (i_reference_mv),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample_mv    (o_sample_mv),
        .o_average_mv   (o_average_mv),
        .o_window_full  (o_window_full)
    );

    always #2 i_clk = ~i_clk;

    // Words still to be offered, and the readings the block owes us, oldest first.
    t_adc_word pending_words[$];
    t_reading  expected_readings[$];

    // Our own copy of the averaging window.
    logic [MV_W-1:0]            voltage_window [DEPTH];
    logic [MV_W+$clog2(DEPTH):0] window_total;
    logic [$clog2(DEPTH)-1:0]   window_slot;
    logic [$clog2(DEPTH):0]     window_count;

    int        words_accepted;
    int        error_count;
    int        watchdog_count;
    int        hold_cycles;
    logic      hold_done;
    int        send_idle_pct;
    int        recv_idle_pct;
    t_adc_word next_word;

    // Battery voltage for one word: raw * vref * (high + low) / (full scale * low),
    // truncated. A zero reference means the reading is invalid and gives zero.
    // Saturation only matters for narrower converters, but it costs nothing here.
    function automatic logic [MV_W-1:0] battery_mv(input t_adc_word w);
        logic [63:0] product;
        logic [63:0] quotient;
        if (w.ref_mv == '0) begin
            return '0;
        end
        product  = 64'(w.sample) * 64'(w.ref_mv) *
                   64'(DIVIDER_HIGH_KOHM + DIVIDER_LOW_KOHM);
        quotient = product / (64'(FULL_SCALE) * 64'(DIVIDER_LOW_KOHM));
        if (quotient > 64'(MV_MAX)) begin
            quotient = 64'(MV_MAX);
        end
        return quotient[MV_W-1:0];
    endfunction

    // Pushes one accepted word into the window model and returns what the block
    // must report for it. While the window fills, the mean is over the words seen
    // so far; once full, the oldest entry drops out of the total.
    function automatic t_reading predict_reading(input t_adc_word w);
        t_reading r;
        r.sample_mv = battery_mv(w);
        if (window_count < DEPTH) begin
            window_count = window_count + 1'b1;
        end else begin
            window_total = window_total - voltage_window[window_slot];
        end
        voltage_window[window_slot] = r.sample_mv;
        window_total = window_total + r.sample_mv;
        window_slot  = (window_slot == DEPTH - 1) ? '0 : window_slot + 1'b1;
        r.average_mv  = MV_W'(window_total / window_count);
        r.window_full = (window_count == DEPTH);
        return r;
    endfunction

    task automatic queue_word(input int sample, input int ref_mv);
        t_adc_word w;
        w.sample = sample[SAMPLE_W-1:0];
        w.ref_mv = ref_mv[REF_W-1:0];
        pending_words.push_back(w);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Idle rates follow the progress of the run: first a slow receiver, then a
    // slow sender, then both sides at full speed.
    always_comb begin
        if (words_accepted < PHASE_A_END) begin
            send_idle_pct = 23;
            recv_idle_pct = 80;
        end else if (words_accepted < PHASE_B_END) begin
            send_idle_pct = 80;
            recv_idle_pct = 23;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // Driver. A word counts as taken at an edge where valid is high and stall is
    // low; that is also where the model predicts its reading. A new word, or a
    // gap, is only chosen once the current word is gone, so a stalled word holds.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_readings.push_back(
                    predict_reading({i_adc_sample, i_reference_mv}));
                words_accepted <= words_accepted + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_word = pending_words.pop_front();
                    i_in_valid     <= 1'b1;
                    i_adc_sample   <= next_word.sample;
                    i_reference_mv <= next_word.ref_mv;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall. Once, well into the full-speed phase, it holds off for a
    // long stretch while the sender keeps offering, so the block backs up and
    // has to stall its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && words_accepted >= HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_cycles <= HOLD_LEN;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor: every reading taken from the block is matched against the oldest
    // prediction, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_readings.size() == 0) begin
                report_mismatch("unexpected reading, sample_mv", o_sample_mv, 0);
            end else begin
                if (o_sample_mv !== expected_readings[0].sample_mv) begin
                    report_mismatch("sample_mv", o_sample_mv,
                                    expected_readings[0].sample_mv);
                end
                if (o_average_mv !== expected_readings[0].average_mv) begin
                    report_mismatch("average_mv", o_average_mv,
                                    expected_readings[0].average_mv);
                end
                if (o_window_full !== expected_readings[0].window_full) begin
                    report_mismatch("window_full", o_window_full,
                                    expected_readings[0].window_full);
                end
                void'(expected_readings.pop_front());
            end
        end
    end

    // Watchdog on handshake activity: a long run of cycles with no word moving on
    // either side means the block has hung.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            watchdog_count <= 0;
        end else if (watchdog_count >= WATCHDOG_MAX) begin
            $display("FAIL");
            $finish;
        end else begin
            watchdog_count <= watchdog_count + 1;
        end
    end

    initial begin
        int pick;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_out_stall    = 1'b0;
        i_adc_sample   = '0;
        i_reference_mv = '0;
        words_accepted = 0;
        error_count    = 0;
        watchdog_count = 0;
        hold_cycles    = 0;
        hold_done      = 1'b0;
        window_total   = '0;
        window_slot    = '0;
        window_count   = '0;
        for (int i = 0; i < DEPTH; i++) begin
            voltage_window[i] = '0;
        end

        // Directed words: field extremes, a zero reference taking a slot in the
        // window while it fills, and enough words to wrap the ring twice so the
        // oldest entry is replaced by both large and zero voltages.
        queue_word(0, 0);
        queue_word(4095, 8191);
        queue_word(4095, 0);
        queue_word(0, 8191);
        queue_word(1, 1);
        queue_word(4095, 1);
        queue_word(1, 8191);
        queue_word(2048, 4096);
        queue_word(4095, 8191);
        queue_word(4095, 8191);
        queue_word(4095, 8191);
        queue_word(4095, 8191);
        queue_word(4095, 8191);
        queue_word(4095, 8191);
        queue_word(4095, 8191);
        queue_word(4095, 8191);
        queue_word(0, 0);
        queue_word(4094, 8190);
        queue_word(2047, 4095);
        queue_word(0, 0);

        // Random words: mostly full range, with a share of zero references,
        // field extremes and tiny values that exercise truncation.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                queue_word($urandom_range(4095), $urandom_range(8191));
            end else if (pick < 80) begin
                queue_word($urandom_range(4095), 0);
            end else if (pick < 90) begin
                queue_word($urandom_range(1) ? 4095 : 0, $urandom_range(1) ? 8191 : 1);
            end else begin
                queue_word($urandom_range(15), $urandom_range(15));
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (pending_words.size() != 0 || i_in_valid ||
                   expected_readings.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/avm_pkg.sv
hdl/avm_conv.sv
hdl/avm_ring.sv
hdl/avm_div.sv
hdl/adc_voltage_moving_average.sv
bench/tb.sv
